// File: hw/rtl/bitmap_slot_allocator_assert.svh
// ----------------------------------------------------------------------------
// Bitmap slot allocator assertion macros
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BITMAP_SLOT_ALLOCATOR_ASSERT_SVH
`define BITMAP_SLOT_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define BSA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BSA_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define BSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: hw/rtl/bsa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator package
// Sizes, result codes, request and result types, and the bit search helper.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int WORDS      = 16;
  localparam int WORD_W     = 64;
  localparam int WORD_IDX_W = 4;
  localparam int BIT_IDX_W  = 6;
  localparam int SLOT_W     = 11;
  localparam int CAPACITY   = WORDS * WORD_W;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic [1:0] OUT_DONE  = 2'd0;
  localparam logic [1:0] OUT_FULL  = 2'd1;
  localparam logic [1:0] OUT_RANGE = 2'd2;

  typedef struct packed {
    logic              mode;
    logic [SLOT_W-1:0] release_slot;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] granted_slot;
    logic [1:0]        outcome;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic release_op;
    logic grant;
    logic advance;
    logic finish_full;
    logic finish_range;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic new_release;
    logic range_bad;
    logic has_clear;
    logic last_word;
  } status_t;

  typedef struct packed {
    logic                 found;
    logic [BIT_IDX_W-1:0] pos;
  } clear_pos_t;

  // Lowest clear bit of a word: pick the lowest byte that is not all ones,
  // then the lowest clear bit inside that byte.
  function automatic clear_pos_t first_clear(input logic [WORD_W-1:0] word);
    clear_pos_t res;
    logic [7:0] byte_full;
    logic [7:0] sel_byte;
    logic [2:0] byte_idx;
    logic [2:0] bit_idx;
    res       = '0;
    byte_idx  = '0;
    bit_idx   = '0;
    for (int i = 0; i < 8; i++) begin
      byte_full[i] = &word[8*i +: 8];
    end
    for (int i = 7; i >= 0; i--) begin
      if (!byte_full[i]) begin
        byte_idx = 3'(i);
      end
    end
    sel_byte = word[8*byte_idx +: 8];
    for (int i = 7; i >= 0; i--) begin
      if (!sel_byte[i]) begin
        bit_idx = 3'(i);
      end
    end
    res.found = ~&byte_full;
    res.pos   = {byte_idx, bit_idx};
    return res;
  endfunction

endpackage

// File: hw/rtl/bsa_ctrl.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator controller
// Sequences capture, release and the word-by-word allocate scan.
// ----------------------------------------------------------------------------
module bsa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  bsa_pkg::status_t status,
  output bsa_pkg::cmd_t    cmd,
  output logic             busy
);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_RELEASE = 2'd1;
  localparam logic [1:0] ST_SCAN    = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = status.new_release ? ST_RELEASE : ST_SCAN;
        end
      end
      ST_RELEASE: begin
        if (status.range_bad) begin
          cmd.finish_range = 1'b1;
        end else begin
          cmd.release_op = 1'b1;
        end
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        priority if (status.has_clear) begin
          cmd.grant  = 1'b1;
          state_next = ST_IDLE;
        end else if (status.last_word) begin
          cmd.finish_full = 1'b1;
          state_next      = ST_IDLE;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// File: hw/rtl/bsa_datapath.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator datapath
// Holds the usage bitmap, the search hint, the scan pointer and the result.
// ----------------------------------------------------------------------------
module bsa_datapath (
  input  logic             clk,
  input  logic             rst,
  input  bsa_pkg::req_t    request,
  input  bsa_pkg::cmd_t    cmd,
  output bsa_pkg::status_t status,
  output logic             done,
  output bsa_pkg::rsp_t    result
);

  logic [bsa_pkg::WORD_W-1:0]     bitmap [bsa_pkg::WORDS];
  logic [bsa_pkg::SLOT_W-1:0]     hint;
  logic [bsa_pkg::WORD_IDX_W-1:0] word_idx;
  bsa_pkg::req_t                  req_q;

  logic [bsa_pkg::SLOT_W-1:0]     hint_less_one;
  logic [bsa_pkg::SLOT_W-1:0]     rel_less_one;
  logic [bsa_pkg::WORD_IDX_W-1:0] rel_word;
  logic [bsa_pkg::BIT_IDX_W-1:0]  rel_bit;
  bsa_pkg::clear_pos_t            clear_pos;
  logic [bsa_pkg::SLOT_W-1:0]     grant_slot;

  assign hint_less_one = hint - bsa_pkg::SLOT_W'(1);
  assign rel_less_one  = req_q.release_slot - bsa_pkg::SLOT_W'(1);
  assign rel_word      = rel_less_one[bsa_pkg::BIT_IDX_W +: bsa_pkg::WORD_IDX_W];
  assign rel_bit       = rel_less_one[bsa_pkg::BIT_IDX_W-1:0];
  assign clear_pos     = bsa_pkg::first_clear(bitmap[word_idx]);
  assign grant_slot    = bsa_pkg::SLOT_W'({word_idx, clear_pos.pos}) + bsa_pkg::SLOT_W'(1);

  assign status.new_release = request.mode;
  assign status.range_bad   = (req_q.release_slot == '0) ||
                              (req_q.release_slot > bsa_pkg::SLOT_W'(bsa_pkg::CAPACITY));
  assign status.has_clear   = clear_pos.found;
  assign status.last_word   = (word_idx == bsa_pkg::WORD_IDX_W'(bsa_pkg::WORDS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bsa_pkg::WORDS; i++) begin
        bitmap[i] <= '0;
      end
      hint <= bsa_pkg::SLOT_W'(1);
      done <= 1'b0;
    end else begin
      done <= cmd.release_op | cmd.grant | cmd.finish_full | cmd.finish_range;
      if (cmd.release_op) begin
        bitmap[rel_word][rel_bit] <= 1'b0;
        if (req_q.release_slot < hint) begin
          hint <= req_q.release_slot;
        end
      end
      if (cmd.grant) begin
        bitmap[word_idx][clear_pos.pos] <= 1'b1;
        hint                            <= grant_slot;
      end
    end
  end

  // The scan starts at the word that holds the hint.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q    <= request;
      word_idx <= hint_less_one[bsa_pkg::BIT_IDX_W +: bsa_pkg::WORD_IDX_W];
    end else if (cmd.advance) begin
      word_idx <= word_idx + bsa_pkg::WORD_IDX_W'(1);
    end
    if (cmd.grant) begin
      result.granted_slot <= grant_slot;
      result.outcome      <= bsa_pkg::OUT_DONE;
    end else if (cmd.release_op) begin
      result.granted_slot <= '0;
      result.outcome      <= bsa_pkg::OUT_DONE;
    end else if (cmd.finish_full) begin
      result.granted_slot <= '0;
      result.outcome      <= bsa_pkg::OUT_FULL;
    end else if (cmd.finish_range) begin
      result.granted_slot <= '0;
      result.outcome      <= bsa_pkg::OUT_RANGE;
    end
  end

endmodule

// File: hw/rtl/bitmap_slot_allocator.sv
// Release: busy in the single release state; the result strobe is registered from it.
// Allocate: busy while k words are tested (1..16) from the hint's word,
// one word per cycle through the single bit-search unit; the strobe is registered from the final word.
// A new request is taken, while not busy, in the same cycle that the previous result is shown.
// Synchronous reset clears the bitmap, sets the hint to slot 1, drops busy and done.
// ----------------------------------------------------------------------------
// Bitmap slot allocator
// First-fit slot allocator over a 16 x 64 bit usage bitmap, slots from 1.
// ----------------------------------------------------------------------------
`include "bitmap_slot_allocator_assert.svh"

module bitmap_slot_allocator (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  bsa_pkg::req_t request,
  output logic          done,
  output bsa_pkg::rsp_t result
);

  bsa_pkg::cmd_t    cmd;
  bsa_pkg::status_t status;
  logic             accept;
  logic             fail_shown;
  logic             grant_shown;
  logic             slot_ok;

  assign accept      = start && !busy;
  assign fail_shown  = done && (result.outcome != bsa_pkg::OUT_DONE);
  assign grant_shown = done && (result.granted_slot != '0);
  assign slot_ok     = (result.granted_slot <= bsa_pkg::SLOT_W'(bsa_pkg::CAPACITY));

  bsa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  bsa_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .status  (status),
    .done    (done),
    .result  (result)
  );

  `BSA_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy, "accepted request without busy")
  `BSA_ASSERT_SAME(a_done_after_busy, clk, rst, done, $past(busy), "result without request")
  `BSA_ASSERT_SAME(a_fail_no_slot, clk, rst, fail_shown, result.granted_slot == '0, "slot on failure")
  `BSA_ASSERT_SAME(a_slot_in_range, clk, rst, grant_shown, slot_ok, "slot beyond capacity")

endmodule

// File: bench/bitmap_slot_allocator_checker.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator checker
// Watches the request and result channels and keeps its own copy of the
// usage bitmap and search hint. Each accepted request yields one predicted
// result, and each result strobe is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  bsa_pkg::req_t request,
  input  logic          done,
  input  bsa_pkg::rsp_t result,
  output int            mismatches,
  output int            outstanding
);

  localparam int PRED_DEPTH = 8;

  logic [bsa_pkg::WORD_W-1:0] slot_map [bsa_pkg::WORDS];
  logic [bsa_pkg::SLOT_W-1:0] hint;
  bsa_pkg::rsp_t              predicted [PRED_DEPTH];
  int                         wr_ptr;
  int                         rd_ptr;
  int                         pred_count;

  initial mismatches = 0;

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Applies one request to the shadow bitmap and returns its result.
  function automatic bsa_pkg::rsp_t allocate_or_release(input bsa_pkg::req_t rq);
    bsa_pkg::rsp_t r;
    int   w;
    int   b;
    int   first_word;
    int   idx;
    logic hit;
    r.granted_slot = '0;
    r.outcome      = bsa_pkg::OUT_DONE;
    hit            = 1'b0;
    if (rq.mode == bsa_pkg::MODE_RELEASE) begin
      if (rq.release_slot == 0 || rq.release_slot > bsa_pkg::CAPACITY) begin
        r.outcome = bsa_pkg::OUT_RANGE;
      end else begin
        idx = int'(rq.release_slot) - 1;
        if (rq.release_slot < hint) hint = rq.release_slot;
        slot_map[idx / bsa_pkg::WORD_W][idx % bsa_pkg::WORD_W] = 1'b0;
      end
    end else begin
      first_word = (hint == 0) ? 0 : (int'(hint) - 1) / bsa_pkg::WORD_W;
      for (w = first_word; w < bsa_pkg::WORDS && !hit; w++) begin
        for (b = 0; b < bsa_pkg::WORD_W && !hit; b++) begin
          if (!slot_map[w][b]) begin
            hit            = 1'b1;
            slot_map[w][b] = 1'b1;
            hint           = bsa_pkg::SLOT_W'(w * bsa_pkg::WORD_W + b + 1);
            r.granted_slot = hint;
          end
        end
      end
      if (!hit) r.outcome = bsa_pkg::OUT_FULL;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    bsa_pkg::rsp_t want;
    if (rst) begin
      for (int i = 0; i < bsa_pkg::WORDS; i++) slot_map[i] = '0;
      hint       = bsa_pkg::SLOT_W'(1);
      wr_ptr     = 0;
      rd_ptr     = 0;
      pred_count = 0;
      outstanding <= 0;
    end else begin
      // A result and the next request can share an edge; the result is older.
      if (done) begin
        if (pred_count == 0) begin
          flag_mismatch("unexpected result, granted_slot", int'(result.granted_slot), 0);
        end else begin
          want       = predicted[rd_ptr];
          rd_ptr     = (rd_ptr + 1) % PRED_DEPTH;
          pred_count = pred_count - 1;
          if (result.granted_slot !== want.granted_slot)
            flag_mismatch("granted_slot", int'(result.granted_slot),
                          int'(want.granted_slot));
          if (result.outcome !== want.outcome)
            flag_mismatch("outcome", int'(result.outcome), int'(want.outcome));
        end
      end
      if (start && !busy) begin
        if (pred_count == PRED_DEPTH) begin
          flag_mismatch("requests without results", pred_count, PRED_DEPTH - 1);
        end else begin
          predicted[wr_ptr] = allocate_or_release(request);
          wr_ptr            = (wr_ptr + 1) % PRED_DEPTH;
          pred_count        = pred_count + 1;
        end
      end
      outstanding <= pred_count;
    end
  end

endmodule

// File: bench/tb_bitmap_slot_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator testbench
// Drives directed and random allocate and release requests in bursts with
// random gaps, then churns with an even mix of releases and allocations,
// while a checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_bitmap_slot_allocator;

  localparam int   CYCLE_LIMIT  = 400000;
  localparam int   RANDOM_ITEMS = 380;
  localparam int   CHURN_ITEMS  = 150;

  logic          clk     = 1'b0;
  logic          rst     = 1'b1;
  logic          start   = 1'b0;
  bsa_pkg::req_t request = '0;
  logic          busy;
  logic          done;
  bsa_pkg::rsp_t result;
  int            mismatches;
  int            outstanding;
  int            cycle_count = 0;
  int            burst_left  = 4;

  bitmap_slot_allocator uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  bitmap_slot_allocator_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .done        (done),
    .result      (result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_bitmap_slot_allocator: errors");
      $finish;
    end
  end

  // Holds start until the request is taken, then closes the burst with a gap
  // when its count runs out. Long bursts give stretches with no idling.
  task automatic issue(input logic m, input logic [bsa_pkg::SLOT_W-1:0] slot);
    start   <= 1'b1;
    request <= '{mode: m, release_slot: slot};
    do @(posedge clk); while (busy);
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
    end
  endtask

  function automatic logic [bsa_pkg::SLOT_W-1:0] pick_release_slot();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 16) return bsa_pkg::SLOT_W'($urandom_range(1, bsa_pkg::CAPACITY));
    if (roll == 16) return bsa_pkg::SLOT_W'(0);
    if (roll == 17) return bsa_pkg::SLOT_W'(bsa_pkg::CAPACITY);
    if (roll == 18) return bsa_pkg::SLOT_W'(bsa_pkg::CAPACITY + 1);
    return bsa_pkg::SLOT_W'($urandom_range(0, (1 << bsa_pkg::SLOT_W) - 1));
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed requests.
    issue(bsa_pkg::MODE_ALLOC, '0);
    issue(bsa_pkg::MODE_ALLOC, '0);
    issue(bsa_pkg::MODE_ALLOC, '0);
    issue(bsa_pkg::MODE_RELEASE, bsa_pkg::SLOT_W'(2));
    issue(bsa_pkg::MODE_ALLOC, '0);
    issue(bsa_pkg::MODE_RELEASE, bsa_pkg::SLOT_W'(0));
    issue(bsa_pkg::MODE_RELEASE, bsa_pkg::SLOT_W'(bsa_pkg::CAPACITY + 1));
    issue(bsa_pkg::MODE_RELEASE, '1);
    issue(bsa_pkg::MODE_RELEASE, bsa_pkg::SLOT_W'(bsa_pkg::CAPACITY));
    issue(bsa_pkg::MODE_RELEASE, bsa_pkg::SLOT_W'(1));
    issue(bsa_pkg::MODE_RELEASE, bsa_pkg::SLOT_W'(1));
    issue(bsa_pkg::MODE_ALLOC, '1);
    issue(bsa_pkg::MODE_RELEASE, bsa_pkg::SLOT_W'(5));
    issue(bsa_pkg::MODE_RELEASE, bsa_pkg::SLOT_W'(64));
    issue(bsa_pkg::MODE_RELEASE, bsa_pkg::SLOT_W'(65));
    issue(bsa_pkg::MODE_ALLOC, '0);
    issue(bsa_pkg::MODE_ALLOC, '0);

    // Random mix, leaning toward allocation so the bitmap fills across words.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 99) < 65)
        issue(bsa_pkg::MODE_ALLOC, bsa_pkg::SLOT_W'($urandom()));
      else
        issue(bsa_pkg::MODE_RELEASE, pick_release_slot());
    end

    // Even mix: a release below the hint lowers the hint, so a later allocate can take the freed slot.
    for (int i = 0; i < CHURN_ITEMS; i++) begin
      if ($urandom_range(0, 1) == 0)
        issue(bsa_pkg::MODE_RELEASE, pick_release_slot());
      else
        issue(bsa_pkg::MODE_ALLOC, bsa_pkg::SLOT_W'($urandom()));
    end

    if (start) start <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_bitmap_slot_allocator: clean");
    end else begin
      $display("tb_bitmap_slot_allocator: errors");
    end
    $finish;
  end

endmodule
